/* rtl/osrb_pkg.sv */
package osrb_pkg;

    localparam int DEF_CAPACITY = 32768;
    localparam int DEF_MAX_READ = 64;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int CMD_W    = 2;

    // input queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // result queue at the output
    localparam int OUT_DEPTH = 4;
    localparam int OAW       = $clog2(OUT_DEPTH);
    localparam int OCW       = $clog2(OUT_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [COUNT_W-1:0]         count;
    } item_t;

    typedef struct packed {
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } back_state_t;

endpackage

/* rtl/overwriting_sample_ring_buffer_unit.sv */
// read path: input queue, decode in ST_IDLE, memory read into rdata_reg, then the result queue
// one write or flush per cycle while no read is in progress; a read of n words holds the sample
//   memory port for a decode step, then one read per word that waits for result queue room
// a read with an empty store or zero length yields no output
// reset: aresetn synchronous, active low; clears pointer, fill count and queues, not the memory
module overwriting_sample_ring_buffer_unit #(
    parameter int CAPACITY = osrb_pkg::DEF_CAPACITY,
    parameter int MAX_READ = osrb_pkg::DEF_MAX_READ
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] sample_in, [22:16] burst_len, [23] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    output logic        m_tlast
);

    osrb_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;

    osrb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    osrb_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/osrb_front.sv */
module osrb_front #(
    parameter int MAX_READ = osrb_pkg::DEF_MAX_READ
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // [15:0] sample_in, [22:16] burst_len, [23] zero
    input  logic [1:0]          s_tuser,   // [1:0] cmd
    output osrb_pkg::item_t     q_item,
    output logic                q_valid,
    input  logic                q_pop
);

    localparam logic [osrb_pkg::COUNT_W-1:0] MAX_R = osrb_pkg::COUNT_W'(MAX_READ);

    osrb_pkg::item_t                q_reg [osrb_pkg::QUEUE_DEPTH];
    logic [osrb_pkg::QAW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [osrb_pkg::QAW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [osrb_pkg::QCW-1:0]       cnt_reg, cnt_next;

    osrb_pkg::item_t                item_in;
    logic                           known;
    logic                           push;
    logic [osrb_pkg::COUNT_W-1:0]   req_raw;

    // decode the command and clamp the read length on the way in
    always_comb begin
        req_raw        = s_tdata[22:16];
        item_in.sample = s_tdata[15:0];
        item_in.count  = (req_raw > MAX_R) ? MAX_R : req_raw;
        item_in.op     = osrb_pkg::OP_WRITE;
        known          = 1'b1;
        case (s_tuser)
            osrb_pkg::CMD_WRITE: item_in.op = osrb_pkg::OP_WRITE;
            osrb_pkg::CMD_READ:  item_in.op = osrb_pkg::OP_READ;
            osrb_pkg::CMD_FLUSH: item_in.op = osrb_pkg::OP_FLUSH;
            default:             known      = 1'b0;
        endcase
    end

    assign s_tready = (cnt_reg < osrb_pkg::QCW'(osrb_pkg::QUEUE_DEPTH));
    // unused command codes are taken and dropped here
    assign push     = s_tvalid && s_tready && known;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid)) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop && q_valid) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* rtl/osrb_back.sv */
module osrb_back #(
    parameter int CAPACITY = osrb_pkg::DEF_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  osrb_pkg::item_t     q_item,
    input  logic                q_valid,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [15:0] sample_out
    output logic                m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > osrb_pkg::COUNT_W) ? FW : osrb_pkg::COUNT_W;
    localparam int PW = ((AW > osrb_pkg::COUNT_W) ? AW : osrb_pkg::COUNT_W) + 1;

    logic signed [osrb_pkg::SAMPLE_W-1:0] mem [CAPACITY];
    logic signed [osrb_pkg::SAMPLE_W-1:0] rdata_reg;

    osrb_pkg::back_state_t          state_reg, state_next;
    logic [AW-1:0]                  wp_reg, wp_next;
    logic [FW-1:0]                  fill_reg, fill_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [osrb_pkg::COUNT_W-1:0]   left_reg, left_next;
    logic                           infl_reg, infl_last_reg;

    osrb_pkg::out_word_t            ofifo_reg [osrb_pkg::OUT_DEPTH];
    logic [osrb_pkg::OAW-1:0]       ohead_reg, otail_reg;
    logic [osrb_pkg::OCW-1:0]       ocnt_reg, ocnt_next;

    logic                           mem_we, mem_re;
    logic                           issue_last;
    logic                           can_issue;
    logic [osrb_pkg::COUNT_W-1:0]   n_clamp;
    logic [PW-1:0]                  wp_ext, n_ext, start_ext;
    logic [AW-1:0]                  wp_inc, pos_inc;
    logic                           opush, opop;
    osrb_pkg::out_word_t            oword;

    // window length limited by the fill count
    always_comb begin
        if (CW'(q_item.count) > CW'(fill_reg)) begin
            n_clamp = osrb_pkg::COUNT_W'(fill_reg);
        end else begin
            n_clamp = q_item.count;
        end
        wp_ext = PW'(wp_reg);
        n_ext  = PW'(n_clamp);
        if (wp_ext >= n_ext) begin
            start_ext = wp_ext - n_ext;
        end else begin
            start_ext = wp_ext + PW'(CAPACITY) - n_ext;
        end
        wp_inc  = (wp_reg == AW'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
        pos_inc = (pos_reg == AW'(CAPACITY - 1)) ? '0 : pos_reg + 1'b1;
    end

    // issue only when the result queue has room for everything in flight
    assign can_issue  = ((ocnt_reg + osrb_pkg::OCW'(infl_reg)) <
                         osrb_pkg::OCW'(osrb_pkg::OUT_DEPTH));
    assign issue_last = (left_reg == osrb_pkg::COUNT_W'(1));

    always_comb begin
        state_next = state_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        case (state_reg)
            osrb_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        osrb_pkg::OP_WRITE: begin
                            mem_we  = 1'b1;
                            wp_next = wp_inc;
                            if (fill_reg != FW'(CAPACITY)) begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        osrb_pkg::OP_READ: begin
                            if (n_clamp != '0) begin
                                pos_next   = start_ext[AW-1:0];
                                left_next  = n_clamp;
                                state_next = osrb_pkg::ST_READ;
                            end
                        end
                        osrb_pkg::OP_FLUSH: begin
                            wp_next   = '0;
                            fill_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            osrb_pkg::ST_READ: begin
                if (can_issue) begin
                    mem_re    = 1'b1;
                    pos_next  = pos_inc;
                    left_next = left_reg - 1'b1;
                    if (issue_last) begin
                        state_next = osrb_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = osrb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= osrb_pkg::ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            left_reg      <= '0;
            infl_reg      <= 1'b0;
            infl_last_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            infl_reg      <= mem_re;
            infl_last_reg <= mem_re && issue_last;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= q_item.sample;
        end
        if (mem_re) begin
            rdata_reg <= mem[pos_reg];
        end
    end

    // result queue
    assign opush       = infl_reg;
    assign opop        = m_tvalid && m_tready;
    assign oword.last   = infl_last_reg;
    assign oword.sample = rdata_reg;

    always_comb begin
        ocnt_next = ocnt_reg;
        if (opush && !opop) begin
            ocnt_next = ocnt_reg + 1'b1;
        end else if (!opush && opop) begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ohead_reg <= '0;
            otail_reg <= '0;
            ocnt_reg  <= '0;
        end else begin
            ocnt_reg <= ocnt_next;
            if (opush) begin
                otail_reg <= otail_reg + 1'b1;
            end
            if (opop) begin
                ohead_reg <= ohead_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (opush) begin
            ofifo_reg[otail_reg] <= oword;
        end
    end

    assign m_tvalid = (ocnt_reg != '0);
    assign m_tdata  = ofifo_reg[ohead_reg].sample;
    assign m_tlast  = ofifo_reg[ohead_reg].last;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(CAPACITY))
        else $error("fill count above capacity");

    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= AW'(CAPACITY - 1))
        else $error("write pointer out of range");

    a_read_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == osrb_pkg::ST_READ) |-> (left_reg != '0))
        else $error("read burst with nothing left");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_re && issue_last) |=> (state_reg == osrb_pkg::ST_IDLE))
        else $error("burst did not end after its last word");

    a_out_room: assert property (@(posedge aclk) disable iff (!aresetn)
        infl_reg |-> (ocnt_reg < osrb_pkg::OCW'(osrb_pkg::OUT_DEPTH)))
        else $error("result queue overflow");
`endif

endmodule
